>>> hw/rtl/tps_pkg.sv
// task priority scheduler package: slot table types, request and result items,
// scan state encoding and slot helper functions
// no dependencies
`timescale 1ns / 1ps

package tps_pkg;

	// number of thread slots, slot 0 is the idle thread
	localparam int THREAD_SLOTS = 8;
	localparam int SLOT_W = $clog2(THREAD_SLOTS);
	localparam int CNT_W = $clog2(THREAD_SLOTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam slot_t IDLE_SLOT = '0;
	localparam slot_t FIRST_USER_SLOT = SLOT_W'(1);
	localparam slot_t LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);
	localparam cnt_t ALL_SLOTS = CNT_W'(THREAD_SLOTS);
	localparam cnt_t USER_SLOTS = CNT_W'(THREAD_SLOTS - 1);
	localparam logic [7:0] IDLE_PRIO = 8'd255;
	localparam logic [8:0] NO_PRIO = 9'd256;

	// request kinds
	typedef enum logic [1:0] {
		K_ADD   = 2'd0,
		K_SLEEP = 2'd1,
		K_TICK  = 2'd2,
		K_SCHED = 2'd3
	} kind_t;

	// slot status codes
	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_READY = 2'd1,
		ST_SLEEP = 2'd2
	} status_t;

	// one slot table entry as stored in the ram
	typedef struct packed {
		status_t     status;
		logic [7:0]  prio;
		logic [31:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t IDLE_ENTRY = '{status: ST_READY, prio: IDLE_PRIO, count: 32'd0};
	localparam entry_t FREE_ENTRY = '{status: ST_FREE, prio: 8'd0, count: 32'd0};

	// input item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  prio;
		logic [31:0] sleep_ticks;
	} req_t;

	// result item
	typedef struct packed {
		logic       ok;
		logic [2:0] new_slot;
		logic [2:0] running_slot;
		logic       woke_any;
	} rsp_t;

	// per-entry flags from the entry update logic
	typedef struct packed {
		logic wr_en;
		logic woke;
		logic ready;
		logic claim;
	} upd_flags_t;

	// scan sequencer states
	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// cyclic successor of a slot
	function automatic slot_t next_slot(input slot_t s);
		slot_t n;
		n = (s == LAST_SLOT) ? IDLE_SLOT : slot_t'(s + 1'b1);
		return n;
	endfunction

	// slot number as reported on the result port
	function automatic logic [2:0] slot_out(input slot_t s);
		logic [2:0] r;
		r = 3'(s);
		return r;
	endfunction

endpackage

>>> hw/rtl/tps_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tps_entry_upd.sv
// read-modify-write logic for one slot entry: add claim, sleep, tick countdown
// depends on tps_pkg
`timescale 1ns / 1ps

module tps_entry_upd (
	input  tps_pkg::req_t      req,
	input  tps_pkg::slot_t     cur_slot,
	input  tps_pkg::slot_t     addr,
	input  tps_pkg::entry_t    rd_entry,
	input  logic               rd_valid,
	input  logic               claimed,
	output tps_pkg::entry_t    wr_entry,
	output tps_pkg::upd_flags_t flags
);
	import tps_pkg::*;

	entry_t base;

	// entries never written read as their reset value
	always_comb begin
		if (rd_valid) begin
			base = rd_entry;
		end else if (addr == IDLE_SLOT) begin
			base = IDLE_ENTRY;
		end else begin
			base = FREE_ENTRY;
		end
	end

	// per-kind modification of the entry
	always_comb begin
		wr_entry = base;
		flags = '0;
		case (req.kind)
			K_ADD: begin
				if (base.status == ST_FREE && !claimed) begin
					wr_entry.status = ST_READY;
					wr_entry.prio = req.prio;
					wr_entry.count = 32'd0;
					flags.wr_en = 1'b1;
					flags.claim = 1'b1;
				end
			end
			K_SLEEP: begin
				if (addr == cur_slot) begin
					wr_entry.status = (req.sleep_ticks != 32'd0) ? ST_SLEEP : ST_READY;
					wr_entry.count = req.sleep_ticks;
					flags.wr_en = 1'b1;
				end
			end
			K_TICK: begin
				if (base.status == ST_SLEEP && base.count != 32'd0) begin
					wr_entry.count = base.count - 32'd1;
					flags.wr_en = 1'b1;
					if (base.count == 32'd1) begin
						wr_entry.status = ST_READY;
						flags.woke = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		flags.ready = (wr_entry.status == ST_READY);
	end

endmodule

>>> hw/rtl/task_priority_scheduler.sv
// task priority scheduler top level: scan sequencer, slot table ram, pick logic
// depends on tps_pkg, tps_ram, tps_entry_upd
`timescale 1ns / 1ps

// Usage:
// An item (req: kind, prio, sleep_ticks) is taken at a rising edge where start
// is high and busy is low. Each item gives exactly one result on rsp, shown for
// one cycle with done high; the receiver cannot stall it.
// The slot table lives in one ram with one entry per slot. Every item that does
// work walks the table one entry a cycle through the ram's registered read port,
// updating each entry on the way back and tracking the best ready slot.
// Walk per item kind, with N = THREAD_SLOTS:
//   schedule, sleep, tick: all N slots, from the one after the runner
//   add thread: the N - 1 user slots, from slot 1
//   sleep or tick before the first schedule: no walk; done rises the cycle after and busy stays low
// The walk length (one ram read per slot) sets the latency. busy falls as done
// rises, so a new item may be taken while the previous result is still on rsp.
// Reset clears the per-entry written flags so every slot reads as its reset
// value (slot 0 ready at priority 255, the rest free); no clearing pass runs.

module task_priority_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tps_pkg::req_t req,
	output logic          done,
	output tps_pkg::rsp_t rsp
);
	import tps_pkg::*;

	state_t              state_q, state_n;
	req_t                req_q;
	cnt_t                cnt_q;
	slot_t               rd_addr_q;
	slot_t               cur_q;
	logic                started_q;
	logic [THREAD_SLOTS-1:0] valid_q;

	logic                vld_s1, last_s1;
	slot_t               addr_s1;

	slot_t               best_q;
	logic [8:0]          best_prio_q;
	logic                sel_q;
	logic                found_q;
	slot_t               new_slot_q;
	logic                woke_q;

	rsp_t                rsp_q;
	logic                done_q;

	logic                acc, immed, issue, finish, take, claim;
	slot_t               best_n;
	logic                sel_n, woke_n;
	slot_t               final_cur;
	logic [ENTRY_W-1:0]  rdata;
	entry_t              wr_entry;
	upd_flags_t          flags;

	assign busy = (state_q == S_SCAN);
	assign acc = start && !busy;
	assign immed = (req.kind inside {K_SLEEP, K_TICK}) && !started_q;
	assign issue = (state_q == S_SCAN) && (cnt_q != '0);
	assign finish = vld_s1 && last_s1;

	// slot table
	tps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(THREAD_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (vld_s1 && flags.wr_en),
		.waddr (addr_s1),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	// entry modify on the read data
	tps_entry_upd u_upd (
		.req      (req_q),
		.cur_slot (cur_q),
		.addr     (addr_s1),
		.rd_entry (entry_t'(rdata)),
		.rd_valid (valid_q[addr_s1]),
		.claimed  (found_q),
		.wr_entry (wr_entry),
		.flags    (flags)
	);

	// best ready slot so far, strict compare keeps the earliest in cyclic order
	always_comb begin
		take = vld_s1 && flags.ready && ({1'b0, wr_entry.prio} < best_prio_q);
		best_n = take ? addr_s1 : best_q;
		sel_n = sel_q || take;
		woke_n = woke_q || (vld_s1 && flags.woke);
		claim = vld_s1 && flags.claim;
		final_cur = sel_n ? best_n : IDLE_SLOT;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && !immed) begin
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// scan control, scheduler state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_addr_q <= IDLE_SLOT;
			cur_q <= IDLE_SLOT;
			started_q <= 1'b0;
			valid_q <= '0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			sel_q <= 1'b0;
			found_q <= 1'b0;
			woke_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (acc && immed) || finish;
			vld_s1 <= issue;
			last_s1 <= issue && (cnt_q == CNT_W'(1));
			if (issue) begin
				cnt_q <= cnt_q - CNT_W'(1);
				rd_addr_q <= next_slot(rd_addr_q);
			end
			if (vld_s1 && flags.wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (vld_s1) begin
				sel_q <= sel_n;
				woke_q <= woke_n;
				if (claim) begin
					found_q <= 1'b1;
				end
			end
			if (acc) begin
				sel_q <= 1'b0;
				found_q <= 1'b0;
				woke_q <= 1'b0;
				if (!immed) begin
					if (req.kind == K_SCHED) begin
						started_q <= 1'b1;
					end
					if (req.kind == K_ADD) begin
						cnt_q <= USER_SLOTS;
						rd_addr_q <= FIRST_USER_SLOT;
					end else begin
						cnt_q <= ALL_SLOTS;
						rd_addr_q <= next_slot(cur_q);
					end
				end
			end
			if (finish) begin
				if (req_q.kind != K_ADD) begin
					cur_q <= final_cur;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr_q;
		if (acc) begin
			req_q <= req;
			best_prio_q <= NO_PRIO;
			best_q <= IDLE_SLOT;
		end
		if (vld_s1 && take) begin
			best_q <= addr_s1;
			best_prio_q <= {1'b0, wr_entry.prio};
		end
		if (claim) begin
			new_slot_q <= addr_s1;
		end
		if (acc && immed) begin
			rsp_q.ok <= 1'b0;
			rsp_q.new_slot <= 3'd0;
			rsp_q.running_slot <= slot_out(cur_q);
			rsp_q.woke_any <= 1'b0;
		end else if (finish) begin
			if (req_q.kind == K_ADD) begin
				rsp_q.ok <= found_q || claim;
				if (claim) begin
					rsp_q.new_slot <= slot_out(addr_s1);
				end else if (found_q) begin
					rsp_q.new_slot <= slot_out(new_slot_q);
				end else begin
					rsp_q.new_slot <= 3'd0;
				end
				rsp_q.running_slot <= slot_out(cur_q);
				rsp_q.woke_any <= 1'b0;
			end else begin
				rsp_q.ok <= 1'b1;
				rsp_q.new_slot <= 3'd0;
				rsp_q.running_slot <= slot_out(final_cur);
				rsp_q.woke_any <= woke_n;
			end
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

endmodule

>>> bench/testbench.sv
// testbench for task_priority_scheduler: directed and random request items,
// each result checked against a local model of the slot table
// depends on tps_pkg and task_priority_scheduler
`timescale 1ns / 1ps

module testbench;
	import tps_pkg::*;

	localparam int GAP_PCT = 19;
	localparam int MAX_PRINTS = 30;
	localparam int DRAIN_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// model of the slot table and the scheduler flags
	status_t     tbl_status [THREAD_SLOTS];
	logic [7:0]  tbl_prio [THREAD_SLOTS];
	logic [31:0] tbl_count [THREAD_SLOTS];
	int          run_slot;
	bit          sched_on;

	rsp_t expected_rsp_q [$];
	int   gap_pct = GAP_PCT;
	int   err_cnt = 0;
	int   items_sent = 0;
	int   rsp_seen = 0;
	int   wake_seen = 0;

	task_priority_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #6 clk = ~clk;

	// one printed line per mismatch, output capped
	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// ready slot with lowest priority number, ties go to the first after the runner
	function automatic int pick_runner();
		int best;
		int best_prio;
		int s;
		best = 0;
		best_prio = 256;
		for (int k = 1; k <= THREAD_SLOTS; k++) begin
			s = (run_slot + k) % THREAD_SLOTS;
			if (tbl_status[s] == ST_READY && int'(tbl_prio[s]) < best_prio) begin
				best = s;
				best_prio = int'(tbl_prio[s]);
			end
		end
		return best;
	endfunction

	// apply one request to the model and return the result it gives
	function automatic rsp_t predict_rsp(input req_t it);
		rsp_t r;
		bit hit;
		r = '0;
		hit = 1'b0;
		case (it.kind)
			K_ADD: begin
				for (int i = 1; i < THREAD_SLOTS; i++) begin
					if (!hit && tbl_status[i] == ST_FREE) begin
						tbl_status[i] = ST_READY;
						tbl_prio[i] = it.prio;
						tbl_count[i] = '0;
						r.ok = 1'b1;
						r.new_slot = 3'(i);
						hit = 1'b1;
					end
				end
			end
			K_SLEEP: begin
				if (sched_on) begin
					tbl_count[run_slot] = it.sleep_ticks;
					tbl_status[run_slot] = (it.sleep_ticks != 0) ? ST_SLEEP : ST_READY;
					run_slot = pick_runner();
					r.ok = 1'b1;
				end
			end
			K_TICK: begin
				if (sched_on) begin
					for (int i = 0; i < THREAD_SLOTS; i++) begin
						if (tbl_status[i] == ST_SLEEP && tbl_count[i] != 0) begin
							tbl_count[i] = tbl_count[i] - 1;
							if (tbl_count[i] == 0) begin
								tbl_status[i] = ST_READY;
								r.woke_any = 1'b1;
							end
						end
					end
					run_slot = pick_runner();
					r.ok = 1'b1;
				end
			end
			default: begin
				sched_on = 1'b1;
				run_slot = pick_runner();
				r.ok = 1'b1;
			end
		endcase
		r.running_slot = 3'(run_slot);
		return r;
	endfunction

	function automatic req_t make_item(input kind_t k, input logic [7:0] p,
			input logic [31:0] t);
		req_t it;
		it.kind = k;
		it.prio = p;
		it.sleep_ticks = t;
		return it;
	endfunction

	// send one item, sometimes after a random gap, and log its expected result
	task automatic send_item(input req_t it);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start <= 1'b1;
		req <= it;
		do @(posedge clk); while (busy);
		expected_rsp_q.push_back(predict_rsp(it));
		items_sent++;
	endtask

	// result checker: every done cycle is compared with the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			rsp_seen++;
			if (rsp.woke_any) begin
				wake_seen++;
			end
			if (expected_rsp_q.size() == 0) begin
				report_mismatch($sformatf("result with no item pending: %p", rsp));
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				if (rsp.ok !== exp_rsp.ok)
					report_mismatch($sformatf("ok got %b exp %b", rsp.ok, exp_rsp.ok));
				if (rsp.new_slot !== exp_rsp.new_slot)
					report_mismatch($sformatf("new_slot got %0d exp %0d",
						rsp.new_slot, exp_rsp.new_slot));
				if (rsp.running_slot !== exp_rsp.running_slot)
					report_mismatch($sformatf("running_slot got %0d exp %0d",
						rsp.running_slot, exp_rsp.running_slot));
				if (rsp.woke_any !== exp_rsp.woke_any)
					report_mismatch($sformatf("woke_any got %b exp %b",
						rsp.woke_any, exp_rsp.woke_any));
			end
		end
	end

	// sleep and tick are ignored until the first schedule
	task automatic test_before_start();
		send_item(make_item(K_TICK, 8'd0, 32'd0));
		send_item(make_item(K_SLEEP, 8'hff, 32'hffff_ffff));
	endtask

	// fill every user slot before start, then one add with no free slot
	task automatic test_fill_table();
		send_item(make_item(K_ADD, 8'd5, 32'd0));
		send_item(make_item(K_ADD, 8'd5, 32'hffff_ffff));
		send_item(make_item(K_ADD, 8'd5, 32'd0));
		send_item(make_item(K_ADD, 8'd255, 32'd0));
		send_item(make_item(K_ADD, 8'd0, 32'd0));
		send_item(make_item(K_ADD, 8'd128, 32'd0));
		send_item(make_item(K_ADD, 8'd5, 32'd0));
		send_item(make_item(K_ADD, 8'd7, 32'd0));
	endtask

	// start, yield, sleep the top thread, then rotate among the tied ones
	task automatic test_round_robin();
		send_item(make_item(K_SCHED, 8'd0, 32'd0));
		send_item(make_item(K_SLEEP, 8'd0, 32'd0));
		send_item(make_item(K_SLEEP, 8'd0, 32'd3));
		send_item(make_item(K_SCHED, 8'd0, 32'd0));
	endtask

	// sleep whatever runs until the idle slot sleeps too, then tick so the two-tick sleepers wake
	task automatic test_all_asleep();
		repeat (THREAD_SLOTS) send_item(make_item(K_SLEEP, 8'd0, 32'd2));
		send_item(make_item(K_SCHED, 8'd0, 32'd0));
		send_item(make_item(K_TICK, 8'd0, 32'd0));
		send_item(make_item(K_TICK, 8'd0, 32'd0));
	endtask

	// mostly short sleeps and ticks so threads keep cycling through the table
	function automatic req_t random_item();
		req_t it;
		int unsigned roll;
		roll = $urandom_range(99);
		it.prio = 8'($urandom);
		it.sleep_ticks = $urandom_range(6);
		if (roll < 10)
			it.kind = K_ADD;
		else if (roll < 45)
			it.kind = K_SLEEP;
		else if (roll < 88)
			it.kind = K_TICK;
		else
			it.kind = K_SCHED;
		if (it.kind == K_SLEEP && $urandom_range(9) == 0) begin
			it.sleep_ticks = $urandom_range(40);
		end
		return it;
	endfunction

	// random mix, with a long stretch without gaps in the middle
	task automatic test_random_mix();
		for (int n = 0; n < 600; n++) begin
			gap_pct = (n >= 200 && n < 350) ? 0 : GAP_PCT;
			send_item(random_item());
		end
		gap_pct = GAP_PCT;
	endtask

	// very long sleeps park threads for good, so they come last
	task automatic test_long_sleep();
		send_item(make_item(K_SLEEP, 8'd0, 32'hffff_ffff));
		repeat (6) begin
			send_item(make_item(K_SLEEP, 8'($urandom), {1'b1, 31'($urandom)}));
			send_item(make_item(K_TICK, 8'd0, 32'd0));
		end
		send_item(make_item(K_SLEEP, 8'd0, 32'($urandom)));
		send_item(make_item(K_TICK, 8'd0, 32'd0));
		send_item(make_item(K_SCHED, 8'd0, 32'd0));
	endtask

	// main sequence
	initial begin
		int guard;
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			tbl_status[i] = ST_FREE;
			tbl_prio[i] = 8'd0;
			tbl_count[i] = 32'd0;
		end
		tbl_status[0] = ST_READY;
		tbl_prio[0] = IDLE_PRIO;
		run_slot = 0;
		sched_on = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_start();
		test_fill_table();
		test_round_robin();
		test_all_asleep();
		test_random_mix();
		test_long_sleep();
		start <= 1'b0;

		guard = 0;
		while (expected_rsp_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (expected_rsp_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
		end
		repeat (4 * THREAD_SLOTS) @(posedge clk);

		$display("sent %0d items, checked %0d results, %0d of them woke a sleeper",
			items_sent, rsp_seen, wake_seen);
		$display("covered start gating, full table, round-robin ties, idle sleep, long sleeps");
		if (err_cnt == 0) begin
			$display("[task_priority_scheduler] OK");
		end else begin
			$display("[task_priority_scheduler] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("timeout with %0d results pending", expected_rsp_q.size());
		$display("[task_priority_scheduler] ERROR");
		$finish;
	end

endmodule

>>> task_priority_scheduler.f
hw/rtl/tps_pkg.sv
hw/rtl/tps_ram.sv
hw/rtl/tps_entry_upd.sv
hw/rtl/task_priority_scheduler.sv
bench/testbench.sv
